FILE: hw/rtl/raster_bilinear_height_sampler_assert.svh
// ----------------------------------------------------------------------------
// raster bilinear height sampler assertion macros
// clocked property checks, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef RASTER_BILINEAR_HEIGHT_SAMPLER_ASSERT_SVH
`define RASTER_BILINEAR_HEIGHT_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define RBHS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rbhs assertion failed");
// condition must never be true outside reset
`define RBHS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rbhs forbidden condition seen");
`else
`define RBHS_ASSERT(label, clk, rst_n, prop)
`define RBHS_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hw/rtl/rbhs_pkg.sv
// ----------------------------------------------------------------------------
// rbhs_pkg
// shared constants, payload types and config bundle of the height sampler
// ----------------------------------------------------------------------------
package rbhs_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_COLS    = 256;
	localparam int MAX_ROWS    = 256;
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COORD_W     = 48;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int INV_W       = 32;
	localparam int SIZE_W      = 9;
	localparam int IDX_W       = 8;
	localparam int ELEV_W      = 16;
	localparam int SCALE_W     = 24;
	localparam int OUT_W       = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;

	// a diff can only map inside when below 2^SPAN_W
	localparam int SPAN_W = 2 * FRAC_BITS + SIZE_W;
	localparam int LO_W   = 32;
	localparam int HI_W   = SPAN_W - LO_W;
	localparam int PROD_W = SPAN_W + INV_W;
	localparam int G_W    = SPAN_W - FRAC_BITS;
	localparam int T_W    = G_W + 1;
	localparam int UP_W   = T_W - FRAC_BITS;

	localparam logic [ELEV_W-1:0] NODATA_CODE = 16'h8000;

	typedef enum logic [0:0] {
		REQ_LOAD   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_NODATA  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_INV_CELL_X   = 3'd2,
		REG_INV_CELL_Y   = 3'd3,
		REG_GRID_WIDTH   = 3'd4,
		REG_GRID_HEIGHT  = 3'd5,
		REG_HEIGHT_SCALE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		req_t                      req_type;
		logic [15:0]               cell_index;
		logic signed [ELEV_W-1:0]  cell_value;
		logic signed [COORD_W-1:0] source_x;
		logic signed [COORD_W-1:0] source_y;
	} in_item_t;

	typedef struct packed {
		status_t                 sample_status;
		logic signed [OUT_W-1:0] height_out;
	} out_item_t;

	// effective configuration, sizes clamped and zero reciprocals forced to one
	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [INV_W-1:0]   inv_x;
		logic [INV_W-1:0]   inv_y;
		logic [SIZE_W-1:0]  cols;
		logic [SIZE_W-1:0]  rows;
		logic [SCALE_W-1:0] scale;
	} cfg_t;

	// located sample: neighbour columns/rows and weights
	typedef struct packed {
		logic                 sample;
		logic                 outside;
		logic [ADDR_W-1:0]    cell_index;
		logic [ELEV_W-1:0]    cell_value;
		logic [IDX_W-1:0]     c0;
		logic [IDX_W-1:0]     c1;
		logic [IDX_W-1:0]     r0;
		logic [IDX_W-1:0]     r1;
		logic [FRAC_BITS-1:0] du;
		logic [FRAC_BITS-1:0] dv;
	} loc_t;

endpackage

FILE: hw/rtl/rbhs_ram.sv
// ----------------------------------------------------------------------------
// rbhs_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module rbhs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: hw/rtl/rbhs_map.sv
// ----------------------------------------------------------------------------
// rbhs_map
// maps source position to grid space and locates clamped neighbours
// ----------------------------------------------------------------------------
module rbhs_map (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  rbhs_pkg::in_item_t in_data,
	input  rbhs_pkg::cfg_t    cfg,
	output logic              s4_valid,
	output rbhs_pkg::loc_t    s4_loc
);
	import rbhs_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]     lo;
		logic [IDX_W-1:0]     hi;
		logic [FRAC_BITS-1:0] w;
	} axis_t;

	function automatic axis_t locate(input logic [G_W-1:0] g, input logic [SIZE_W-1:0] cells);
		logic [T_W-1:0]  t;
		logic [UP_W-1:0] up;
		logic [UP_W-1:0] last;
		axis_t           a;
		t    = {1'b0, g} + T_W'(1 << (FRAC_BITS - 1));
		up   = t[T_W-1:FRAC_BITS];
		last = UP_W'(cells) - UP_W'(1);
		a.lo = (up == '0) ? '0 : IDX_W'(up - UP_W'(1));
		a.hi = (up > last) ? IDX_W'(last) : IDX_W'(up);
		a.w  = t[FRAC_BITS-1:0];
		return a;
	endfunction

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 sample_s1, sample_s2, sample_s3;
	logic [ADDR_W-1:0]    index_s1, index_s2, index_s3;
	logic [ELEV_W-1:0]    value_s1, value_s2, value_s3;
	logic [DIFF_W-1:0]    dx_s1, dy_s1;
	logic                 oorx_s2, oory_s2;
	logic [LO_W+INV_W-1:0] plox_s2, ploy_s2;
	logic [HI_W+INV_W-1:0] phix_s2, phiy_s2;
	logic                 outside_s3;
	logic [G_W-1:0]       gx_s3, gy_s3;
	logic [PROD_W-1:0]    prodx, prody;
	logic                 outx, outy;
	axis_t                ax, ay;

	// stage 1: offsets from origin, y grows southward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= (in_data.req_type == REQ_SAMPLE);
			index_s1  <= in_data.cell_index;
			value_s1  <= in_data.cell_value;
			dx_s1     <= {in_data.source_x[COORD_W-1], in_data.source_x}
			           - {cfg.origin_x[COORD_W-1], cfg.origin_x};
			dy_s1     <= {cfg.origin_y[COORD_W-1], cfg.origin_y}
			           - {in_data.source_y[COORD_W-1], in_data.source_y};
		end
	end

	// stage 2: split products, a negative or huge offset is outside at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s2 <= sample_s1;
			index_s2  <= index_s1;
			value_s2  <= value_s1;
			oorx_s2   <= dx_s1[DIFF_W-1] | (|dx_s1[DIFF_W-2:SPAN_W]);
			oory_s2   <= dy_s1[DIFF_W-1] | (|dy_s1[DIFF_W-2:SPAN_W]);
			plox_s2   <= dx_s1[LO_W-1:0] * cfg.inv_x;
			ploy_s2   <= dy_s1[LO_W-1:0] * cfg.inv_y;
			phix_s2   <= dx_s1[SPAN_W-1:LO_W] * cfg.inv_x;
			phiy_s2   <= dy_s1[SPAN_W-1:LO_W] * cfg.inv_y;
		end
	end

	// stage 3: combine partials, compare against closed coverage edge
	always_comb begin
		prodx = PROD_W'(plox_s2) + {phix_s2, {LO_W{1'b0}}};
		prody = PROD_W'(ploy_s2) + {phiy_s2, {LO_W{1'b0}}};
		outx  = oorx_s2 | (prodx > PROD_W'({cfg.cols, {(2 * FRAC_BITS){1'b0}}}));
		outy  = oory_s2 | (prody > PROD_W'({cfg.rows, {(2 * FRAC_BITS){1'b0}}}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s3  <= sample_s2;
			index_s3   <= index_s2;
			value_s3   <= value_s2;
			outside_s3 <= outx | outy;
			gx_s3      <= prodx[SPAN_W-1:FRAC_BITS];
			gy_s3      <= prody[SPAN_W-1:FRAC_BITS];
		end
	end

	// stage 4: cell centre split and edge clamp
	always_comb begin
		ax = locate(gx_s3, cfg.cols);
		ay = locate(gy_s3, cfg.rows);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_valid <= 1'b0;
		end else if (en) begin
			s4_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s4_loc.sample     <= sample_s3;
			s4_loc.outside    <= outside_s3;
			s4_loc.cell_index <= index_s3;
			s4_loc.cell_value <= value_s3;
			s4_loc.c0         <= ax.lo;
			s4_loc.c1         <= ax.hi;
			s4_loc.r0         <= ay.lo;
			s4_loc.r1         <= ay.hi;
			s4_loc.du         <= ax.w;
			s4_loc.dv         <= ay.w;
		end
	end

endmodule

FILE: hw/rtl/rbhs_interp.sv
// ----------------------------------------------------------------------------
// rbhs_interp
// no-data check, bilinear blend, unit scaling and saturation
// ----------------------------------------------------------------------------
module rbhs_interp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         push,
	input  rbhs_pkg::loc_t               loc,
	input  logic                         cap,
	input  logic [rbhs_pkg::ELEV_W-1:0]  rd_a,
	input  logic [rbhs_pkg::ELEV_W-1:0]  rd_b,
	input  logic [rbhs_pkg::SCALE_W-1:0] scale,
	output logic                         res_valid,
	output rbhs_pkg::out_item_t          res
);
	import rbhs_pkg::*;

	localparam int WGT_W = FRAC_BITS + 2;
	localparam int L1_W  = ELEV_W + WGT_W + 1;
	localparam int TOP_W = ELEV_W + FRAC_BITS + 1;
	localparam int VF_W  = TOP_W + WGT_W + 1;
	localparam int V_W   = TOP_W + FRAC_BITS;
	localparam int HS_W  = V_W - FRAC_BITS;
	localparam int P_W   = HS_W + SCALE_W + 1;
	localparam int R_W   = P_W - FRAC_BITS;

	logic                   valid_s5, valid_s6, valid_s7, valid_s8;
	logic                   sample_s5, sample_s6, sample_s7, sample_s8;
	logic                   outside_s5;
	logic [FRAC_BITS-1:0]   du_s5, dv_s5, dv_s6;
	logic [ELEV_W-1:0]      h00_q, h10_q;
	status_t                st_s6, st_s7, st_s8;
	logic signed [TOP_W-1:0] top_s6, bot_s6;
	logic signed [V_W-1:0]  v_s7;
	logic signed [P_W-1:0]  prod_s8;

	logic signed [WGT_W-1:0] wu0, wu1, wv0, wv1;
	logic signed [L1_W-1:0]  top_c, bot_c;
	logic signed [VF_W-1:0]  v_c;
	logic                    nodata;
	status_t                 st_c;
	logic [V_W-1:0]          hs_sum;
	logic signed [HS_W-1:0]  hs;
	logic signed [SCALE_W:0] sc;
	logic signed [P_W-1:0]   prod_c;
	logic [P_W-1:0]          r_sum;
	logic [R_W-1:0]          r;
	logic [OUT_W-1:0]        sat;

	// first row pair is held while the second row is read
	always_ff @(posedge clk) begin
		if (en && cap) begin
			h00_q <= rd_a;
			h10_q <= rd_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s5 <= push;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// stage 5: second row on the ram outputs, blend along x
	always_comb begin
		wu1    = $signed(WGT_W'(du_s5));
		wu0    = $signed(WGT_W'(1 << FRAC_BITS) - WGT_W'(du_s5));
		top_c  = L1_W'($signed(h00_q) * wu0) + L1_W'($signed(h10_q) * wu1);
		bot_c  = L1_W'($signed(rd_a) * wu0) + L1_W'($signed(rd_b) * wu1);
		nodata = (h00_q == NODATA_CODE) || (h10_q == NODATA_CODE)
		      || (rd_a == NODATA_CODE) || (rd_b == NODATA_CODE);
		if (outside_s5) begin
			st_c = ST_OUTSIDE;
		end else if (nodata) begin
			st_c = ST_NODATA;
		end else begin
			st_c = ST_VALID;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s5  <= loc.sample;
			outside_s5 <= loc.outside;
			du_s5      <= loc.du;
			dv_s5      <= loc.dv;
			sample_s6  <= sample_s5;
			st_s6      <= st_c;
			dv_s6      <= dv_s5;
			top_s6     <= top_c[TOP_W-1:0];
			bot_s6     <= bot_c[TOP_W-1:0];
		end
	end

	// stage 6: blend along y
	always_comb begin
		wv1 = $signed(WGT_W'(dv_s6));
		wv0 = $signed(WGT_W'(1 << FRAC_BITS) - WGT_W'(dv_s6));
		v_c = VF_W'(top_s6 * wv0) + VF_W'(bot_s6 * wv1);
	end

	// stage 7: round to frac bits and scale
	always_comb begin
		hs_sum = v_s7 + V_W'(1 << (FRAC_BITS - 1));
		hs     = $signed(hs_sum[V_W-1:FRAC_BITS]);
		sc     = $signed({1'b0, scale});
		prod_c = hs * sc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s7 <= sample_s6;
			st_s7     <= st_s6;
			v_s7      <= v_c[V_W-1:0];
			sample_s8 <= sample_s7;
			st_s8     <= st_s7;
			prod_s8   <= prod_c;
		end
	end

	// stage 8: round again and saturate
	always_comb begin
		r_sum = prod_s8 + P_W'(1 << (FRAC_BITS - 1));
		r     = r_sum[P_W-1:FRAC_BITS];
		if (!r[R_W-1] && (|r[R_W-2:OUT_W-1])) begin
			sat = {1'b0, {(OUT_W - 1){1'b1}}};
		end else if (r[R_W-1] && !(&r[R_W-2:OUT_W-1])) begin
			sat = {1'b1, {(OUT_W - 1){1'b0}}};
		end else begin
			sat = r[OUT_W-1:0];
		end
		res_valid         = valid_s8 && sample_s8;
		res.sample_status = st_s8;
		res.height_out    = (st_s8 == ST_VALID) ? $signed(sat) : '0;
	end

endmodule

FILE: hw/rtl/raster_bilinear_height_sampler.sv
// a sample outside coverage skips both grid row reads and so leaves the pipeline sooner
// one load beat per cycle unless the pipeline stalls; a sample inside coverage blocks new beats
// while its first grid row is read, as the two memory read ports fetch one grid row per cycle
// output register lets a new beat in while the previous result waits to be taken
// reset: configuration returns to defaults and the pipeline empties
// reset: the elevation memory is not cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
// raster_bilinear_height_sampler
// bilinear elevation lookup over a loaded grid with clamped edges
// ----------------------------------------------------------------------------
`include "raster_bilinear_height_sampler_assert.svh"

module raster_bilinear_height_sampler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rbhs_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rbhs_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [rbhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbhs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rbhs_pkg::*;

	// configuration registers
	logic [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [INV_W-1:0]   inv_x_q, inv_y_q;
	logic [SIZE_W-1:0]  cols_q, rows_q;
	logic [SCALE_W-1:0] scale_q;
	cfg_t               cfg;

	// pipeline control
	logic        out_load;   // output register may take a new result
	logic        adv;        // whole pipeline may move
	logic        front_adv;  // mapping stages may move
	logic        hold4;      // sample at the memory stage needs its second row read
	logic        phase_q;    // second row read in progress
	logic        s4_valid;
	loc_t        s4_loc;
	logic        ram_we, ram_re;
	logic [IDX_W-1:0]        row;
	logic [IDX_W+SIZE_W-1:0] row_base;
	logic [ADDR_W-1:0]       raddr_a, raddr_b;
	logic [ELEV_W-1:0]       rdata_a, rdata_b;
	logic                    res_valid;
	out_item_t               res;
	logic                    out_valid_q;
	out_item_t               out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_x_q    <= INV_W'(1 << FRAC_BITS);
			inv_y_q    <= INV_W'(1 << FRAC_BITS);
			cols_q     <= SIZE_W'(MAX_COLS);
			rows_q     <= SIZE_W'(MAX_ROWS);
			scale_q    <= SCALE_W'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:     origin_x_q <= cfg_wdata[COORD_W-1:0];
				REG_ORIGIN_Y:     origin_y_q <= cfg_wdata[COORD_W-1:0];
				REG_INV_CELL_X:   inv_x_q    <= cfg_wdata[INV_W-1:0];
				REG_INV_CELL_Y:   inv_y_q    <= cfg_wdata[INV_W-1:0];
				REG_GRID_WIDTH:   cols_q     <= cfg_wdata[SIZE_W-1:0];
				REG_GRID_HEIGHT:  rows_q     <= cfg_wdata[SIZE_W-1:0];
				REG_HEIGHT_SCALE: scale_q    <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective values: grid size clamped to the store, zero reciprocal acts as one
	always_comb begin
		cfg.origin_x = origin_x_q;
		cfg.origin_y = origin_y_q;
		cfg.inv_x    = (inv_x_q == '0) ? INV_W'(1) : inv_x_q;
		cfg.inv_y    = (inv_y_q == '0) ? INV_W'(1) : inv_y_q;
		cfg.cols     = (cols_q == '0) ? SIZE_W'(1)
		             : (cols_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_q;
		cfg.rows     = (rows_q == '0) ? SIZE_W'(1)
		             : (rows_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_q;
		cfg.scale    = scale_q;
	end

	// everything moves together unless a result at the last stage meets a full
	// output register that is not taken;
	// a sample inside coverage holds the mapping stages while its first row is read
	always_comb begin
		out_load  = !out_valid_q || out_ready;
		adv       = out_load || !res_valid;
		hold4     = s4_valid && s4_loc.sample && !s4_loc.outside && !phase_q;
		front_adv = adv && !hold4;
		in_ready  = front_adv;
	end

	rbhs_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (front_adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.cfg      (cfg),
		.s4_valid (s4_valid),
		.s4_loc   (s4_loc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (adv) begin
			phase_q <= hold4;
		end
	end

	// memory stage: loads write in order with sample reads, so a read
	// always sees every earlier load without forwarding
	always_comb begin
		ram_we   = adv && s4_valid && !s4_loc.sample;
		ram_re   = adv && s4_valid && s4_loc.sample && !s4_loc.outside;
		row      = phase_q ? s4_loc.r1 : s4_loc.r0;
		row_base = row * cfg.cols;
		raddr_a  = ADDR_W'(row_base + (IDX_W + SIZE_W)'(s4_loc.c0));
		raddr_b  = ADDR_W'(row_base + (IDX_W + SIZE_W)'(s4_loc.c1));
	end

	rbhs_ram #(
		.WIDTH (ELEV_W),
		.DEPTH (STORE_DEPTH)
	) u_elev_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (s4_loc.cell_index),
		.wdata   (s4_loc.cell_value),
		.re      (ram_re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	rbhs_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.push      (s4_valid && !hold4),
		.loc       (s4_loc),
		.cap       (phase_q),
		.rd_a      (rdata_a),
		.rd_b      (rdata_b),
		.scale     (cfg.scale),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register, one result beat per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// second row phase only for an in-coverage sample at the memory stage
	`RBHS_ASSERT(a_phase_owner, clk, arst_n, phase_q |-> s4_valid && s4_loc.sample && !s4_loc.outside)
	// a load write never shares a cycle with a sample read
	`RBHS_NEVER(a_ram_excl, clk, arst_n, ram_we && ram_re)
	// no new beat while the memory stage reads its first row
	`RBHS_ASSERT(a_hold_blocks, clk, arst_n, hold4 |-> !in_ready)
	// the second row phase only follows a first row read that advanced
	`RBHS_ASSERT(a_phase_seq, clk, arst_n, $rose(phase_q) |-> $past(adv && hold4))

endmodule
